### rtl/bis_pkg.sv
// bis_pkg: shared constants, codes and payload types of the bilinear image scaler
// used by every module of the block but bis_ram; depends on nothing
package bis_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int COL_W          = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W          = $clog2(MAX_SRC_HEIGHT);
  localparam int BANK_DEPTH     = (MAX_SRC_WIDTH / 2) * (MAX_SRC_HEIGHT / 2);

  localparam int DST_W  = 13;
  localparam int ORG_W  = 24;
  localparam int INV_W  = 24;
  localparam int SIZE_W = 9;
  localparam int PIX_W  = 32;
  localparam int CH_W   = 8;
  localparam int NUM_CH = 4;
  localparam int IDX_W  = 3;

  localparam int REM_STAGES = 16;
  localparam int AX_LAT     = REM_STAGES + 3;
  localparam int LATENCY    = REM_STAGES + 8;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    CFG_TILE_MODE   = 3'd0,
    CFG_ORIGIN_X    = 3'd1,
    CFG_ORIGIN_Y    = 3'd2,
    CFG_INV_SCALE_X = 3'd3,
    CFG_INV_SCALE_Y = 3'd4,
    CFG_BACKGROUND  = 3'd5,
    CFG_SRC_WIDTH   = 3'd6,
    CFG_SRC_HEIGHT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             operation;
    logic [7:0]       src_col;
    logic [7:0]       src_row;
    logic [PIX_W-1:0] pixel_in;
    logic [DST_W-1:0] dst_col;
    logic [DST_W-1:0] dst_row;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             sampled;
  } result_t;

  typedef struct packed {
    logic             in_src;
    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] c1;
    logic [CH_W-1:0]  wt;
  } axis_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v, input int max);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_W'(max)) r = SIZE_W'(max);
    else r = v;
    return r;
  endfunction

endpackage

### rtl/bis_ram.sv
// bis_ram: generic one-write one-read memory with registered read data
// no dependencies
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bis_axis.sv
// bis_axis: per-axis coordinate lane: scaled mapping, tile wrap remainder, neighbor split
// depends on bis_pkg
module bis_axis (
  input  logic                          clk,
  input  logic [bis_pkg::DST_W-1:0]     dst,
  input  logic signed [bis_pkg::ORG_W-1:0] origin,
  input  logic [bis_pkg::INV_W-1:0]     inv,
  input  logic [bis_pkg::SIZE_W-1:0]    size,
  input  logic                          tile,
  output bis_pkg::axis_t                ax
);

  function automatic logic [bis_pkg::SIZE_W-1:0] rem_step(
    input logic [bis_pkg::SIZE_W-1:0] r,
    input logic                       b,
    input logic [bis_pkg::SIZE_W-1:0] m
  );
    logic [bis_pkg::SIZE_W:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[bis_pkg::SIZE_W-1:0];
  endfunction

  logic signed [25:0]             d_in;
  logic [16:0]                    g_in;
  logic [16:0]                    g_neg;
  logic [15:0]                    mag_in;
  logic signed [25:0]             d_q   [bis_pkg::REM_STAGES+1];
  logic [15:0]                    mag_q [bis_pkg::REM_STAGES+1];
  logic                           neg_q [bis_pkg::REM_STAGES+1];
  logic [bis_pkg::SIZE_W-1:0]     rem_q [bis_pkg::REM_STAGES+1];
  logic signed [50:0]             u_q;
  logic [bis_pkg::COL_W-1:0]      wrap_q;
  logic [bis_pkg::SIZE_W-1:0]     size_m1;
  logic signed [50:0]             s;
  logic signed [50:0]             hi_s;
  logic [49:0]                    lim;
  logic [31:0]                    sc;
  logic [bis_pkg::SIZE_W-1:0]     c1n;
  bis_pkg::axis_t                 ax_next;

  assign d_in   = $signed({5'd0, dst, 8'h80}) - $signed({{2{origin[23]}}, origin});
  assign g_in   = {origin[23], origin[23:8]} + {4'd0, dst};
  assign g_neg  = 17'(-g_in);
  assign mag_in = g_in[16] ? g_neg[15:0] : g_in[15:0];

  always_ff @(posedge clk) begin
    d_q[0]   <= d_in;
    mag_q[0] <= mag_in;
    neg_q[0] <= g_in[16];
    rem_q[0] <= '0;
  end

  for (genvar k = 1; k <= bis_pkg::REM_STAGES; k++) begin : g_rem
    always_ff @(posedge clk) begin
      d_q[k]   <= d_q[k-1];
      mag_q[k] <= mag_q[k-1];
      neg_q[k] <= neg_q[k-1];
      rem_q[k] <= rem_step(rem_q[k-1], mag_q[k-1][bis_pkg::REM_STAGES-k], size);
    end
  end

  always_ff @(posedge clk) begin
    u_q <= d_q[bis_pkg::REM_STAGES] * $signed({1'b0, inv});
    if (neg_q[bis_pkg::REM_STAGES] && rem_q[bis_pkg::REM_STAGES] != '0) begin
      wrap_q <= bis_pkg::COL_W'(size - rem_q[bis_pkg::REM_STAGES]);
    end else begin
      wrap_q <= rem_q[bis_pkg::REM_STAGES][bis_pkg::COL_W-1:0];
    end
  end

  // clamp sample point to the source and split into neighbors and weight; in tile mode use the wrap remainder
  always_comb begin
    size_m1 = size - 9'd1;
    s       = u_q - 51'sd8388608;
    hi_s    = $signed({18'd0, size_m1, 24'd0});
    lim     = {17'd0, size, 24'd0};
    if (s < 0) sc = '0;
    else if (s > hi_s) sc = hi_s[31:0];
    else sc = s[31:0];
    c1n = {1'b0, sc[31:24]} + 9'd1;
    if (tile) begin
      ax_next.in_src = 1'b1;
      ax_next.c0     = wrap_q;
      ax_next.c1     = wrap_q;
      ax_next.wt     = '0;
    end else begin
      ax_next.in_src = !u_q[50] && (u_q[49:0] < lim);
      ax_next.c0     = sc[31:24];
      ax_next.c1     = (c1n < size) ? c1n[7:0] : size_m1[7:0];
      ax_next.wt     = sc[23:16];
    end
  end

  always_ff @(posedge clk) begin
    ax <= ax_next;
  end

endmodule

### rtl/bis_lane.sv
// bis_lane: one channel of the bilinear blend, three register stages
// depends on bis_pkg
module bis_lane (
  input  logic                     clk,
  input  logic [bis_pkg::CH_W-1:0] a,
  input  logic [bis_pkg::CH_W-1:0] b,
  input  logic [bis_pkg::CH_W-1:0] c,
  input  logic [bis_pkg::CH_W-1:0] d,
  input  logic [bis_pkg::CH_W-1:0] fx,
  input  logic [bis_pkg::CH_W-1:0] fy,
  output logic [bis_pkg::CH_W-1:0] q
);

  logic [8:0]  ifx;
  logic [8:0]  ify;
  logic [16:0] top_n;
  logic [16:0] bot_n;
  logic [15:0] top_q;
  logic [15:0] bot_q;
  logic [7:0]  fy_q;
  logic [24:0] v_n;
  logic [23:0] v_q;
  logic [24:0] rnd;

  assign ifx   = 9'd256 - {1'b0, fx};
  assign ify   = 9'd256 - {1'b0, fy_q};
  assign top_n = {9'd0, a} * {8'd0, ifx} + {9'd0, b} * {9'd0, fx};
  assign bot_n = {9'd0, c} * {8'd0, ifx} + {9'd0, d} * {9'd0, fx};
  assign v_n   = {9'd0, top_q} * {16'd0, ify} + {9'd0, bot_q} * {17'd0, fy_q};
  assign rnd   = {1'b0, v_q} + 25'h8000;

  always_ff @(posedge clk) begin
    top_q <= top_n[15:0];
    bot_q <= bot_n[15:0];
    fy_q  <= fy;
    v_q   <= v_n[23:0];
    q     <= (rnd[24:16] > 9'd255) ? 8'hFF : rnd[23:16];
  end

endmodule

### rtl/bilinear_image_scaler_unit.sv
// bilinear_image_scaler_unit: top level, config registers, banked source store,
// coordinate lanes, channel lanes and result merge; depends on bis_pkg, bis_ram,
// bis_axis, bis_lane
//
//   channel   signals                               direction  handshake
//   item      start, busy, item                     in         start & !busy
//   result    done, result                          out        done, one cycle
//   config    cfg_valid, cfg_ready, cfg_index/data  in         cfg_valid & cfg_ready
//
// one item per cycle while busy is low; most of a request's path to its result is
// the 16-stage tile wrap remainder in each coordinate lane
// loads reach the store at the same stage as request reads, so order is kept
// busy is high during reset and in the cycle after it; results cannot be stalled
// the store needs no clearing pass after reset
module bilinear_image_scaler_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  bis_pkg::item_t              item,
  output logic                        done,
  output bis_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bis_pkg::IDX_W-1:0]   cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam int BAW = $clog2(bis_pkg::BANK_DEPTH);

  logic                              tile_mode;
  logic signed [bis_pkg::ORG_W-1:0]  origin_x;
  logic signed [bis_pkg::ORG_W-1:0]  origin_y;
  logic [bis_pkg::INV_W-1:0]         inv_scale_x;
  logic [bis_pkg::INV_W-1:0]         inv_scale_y;
  logic [bis_pkg::PIX_W-1:0]         background_color;
  logic [bis_pkg::SIZE_W-1:0]        src_width;
  logic [bis_pkg::SIZE_W-1:0]        src_height;
  logic [bis_pkg::SIZE_W-1:0]        size_w;
  logic [bis_pkg::SIZE_W-1:0]        size_h;

  logic                              accept;
  logic [bis_pkg::AX_LAT-1:0]        vld_q;
  logic                              op_q   [bis_pkg::AX_LAT];
  logic [bis_pkg::COL_W-1:0]         lcol_q [bis_pkg::AX_LAT];
  logic [bis_pkg::ROW_W-1:0]         lrow_q [bis_pkg::AX_LAT];
  logic [bis_pkg::PIX_W-1:0]         lpix_q [bis_pkg::AX_LAT];

  bis_pkg::axis_t                    ax_x;
  bis_pkg::axis_t                    ax_y;

  logic                              load_en;
  logic                              req_en;
  logic [bis_pkg::PIX_W-1:0]         bank_q [4];

  logic                              rd_vld;
  logic                              rd_samp;
  logic [bis_pkg::CH_W-1:0]          rd_fx;
  logic [bis_pkg::CH_W-1:0]          rd_fy;
  logic                              px0;
  logic                              px1;
  logic                              py0;
  logic                              py1;
  logic [bis_pkg::PIX_W-1:0]         p00;
  logic [bis_pkg::PIX_W-1:0]         p10;
  logic [bis_pkg::PIX_W-1:0]         p01;
  logic [bis_pkg::PIX_W-1:0]         p11;
  logic [bis_pkg::CH_W-1:0]          lane_q [bis_pkg::NUM_CH];
  logic [2:0]                        vld_l;
  logic [2:0]                        samp_l;
  logic [bis_pkg::PIX_W-1:0]         blend;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign size_w    = bis_pkg::clamp_size(src_width, bis_pkg::MAX_SRC_WIDTH);
  assign size_h    = bis_pkg::clamp_size(src_height, bis_pkg::MAX_SRC_HEIGHT);

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_mode        <= 1'b0;
      origin_x         <= '0;
      origin_y         <= '0;
      inv_scale_x      <= 24'd65536;
      inv_scale_y      <= 24'd65536;
      background_color <= 32'hFF000000;
      src_width        <= 9'd256;
      src_height       <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bis_pkg::CFG_TILE_MODE:   tile_mode        <= cfg_data[0];
        bis_pkg::CFG_ORIGIN_X:    origin_x         <= cfg_data[23:0];
        bis_pkg::CFG_ORIGIN_Y:    origin_y         <= cfg_data[23:0];
        bis_pkg::CFG_INV_SCALE_X: inv_scale_x      <= cfg_data[23:0];
        bis_pkg::CFG_INV_SCALE_Y: inv_scale_y      <= cfg_data[23:0];
        bis_pkg::CFG_BACKGROUND:  background_color <= cfg_data;
        bis_pkg::CFG_SRC_WIDTH:   src_width        <= cfg_data[8:0];
        bis_pkg::CFG_SRC_HEIGHT:  src_height       <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // transaction control follows the coordinate lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[bis_pkg::AX_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    op_q[0]   <= item.operation;
    lcol_q[0] <= item.src_col;
    lrow_q[0] <= item.src_row;
    lpix_q[0] <= item.pixel_in;
  end

  for (genvar k = 1; k < bis_pkg::AX_LAT; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      op_q[k]   <= op_q[k-1];
      lcol_q[k] <= lcol_q[k-1];
      lrow_q[k] <= lrow_q[k-1];
      lpix_q[k] <= lpix_q[k-1];
    end
  end

  bis_axis u_ax_x (
    .clk    (clk),
    .dst    (item.dst_col),
    .origin (origin_x),
    .inv    (inv_scale_x),
    .size   (size_w),
    .tile   (tile_mode),
    .ax     (ax_x)
  );

  bis_axis u_ax_y (
    .clk    (clk),
    .dst    (item.dst_row),
    .origin (origin_y),
    .inv    (inv_scale_y),
    .size   (size_h),
    .tile   (tile_mode),
    .ax     (ax_y)
  );

  assign load_en = vld_q[bis_pkg::AX_LAT-1] && (op_q[bis_pkg::AX_LAT-1] == bis_pkg::OP_LOAD);
  assign req_en  = vld_q[bis_pkg::AX_LAT-1] && (op_q[bis_pkg::AX_LAT-1] == bis_pkg::OP_REQUEST);

  // four banks by column and row parity give all four neighbors in the same cycle
  for (genvar by = 0; by < 2; by++) begin : g_by
    for (genvar bx = 0; bx < 2; bx++) begin : g_bx
      logic [bis_pkg::COL_W-1:0] rcol;
      logic [bis_pkg::ROW_W-1:0] rrow;
      logic                      we;

      assign rcol = (ax_x.c0[0] == 1'(bx)) ? ax_x.c0 : ax_x.c1;
      assign rrow = (ax_y.c0[0] == 1'(by)) ? ax_y.c0 : ax_y.c1;
      assign we   = load_en && (lcol_q[bis_pkg::AX_LAT-1][0] == 1'(bx))
                    && (lrow_q[bis_pkg::AX_LAT-1][0] == 1'(by));

      bis_ram #(
        .WIDTH (bis_pkg::PIX_W),
        .DEPTH (bis_pkg::BANK_DEPTH)
      ) u_bank (
        .clk   (clk),
        .we    (we),
        .waddr (BAW'({lrow_q[bis_pkg::AX_LAT-1][bis_pkg::ROW_W-1:1],
                      lcol_q[bis_pkg::AX_LAT-1][bis_pkg::COL_W-1:1]})),
        .wdata (lpix_q[bis_pkg::AX_LAT-1]),
        .raddr (BAW'({rrow[bis_pkg::ROW_W-1:1], rcol[bis_pkg::COL_W-1:1]})),
        .rdata (bank_q[by*2+bx])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= req_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_samp <= ax_x.in_src && ax_y.in_src;
    rd_fx   <= ax_x.wt;
    rd_fy   <= ax_y.wt;
    px0     <= ax_x.c0[0];
    px1     <= ax_x.c1[0];
    py0     <= ax_y.c0[0];
    py1     <= ax_y.c1[0];
  end

  assign p00 = bank_q[{py0, px0}];
  assign p10 = bank_q[{py0, px1}];
  assign p01 = bank_q[{py1, px0}];
  assign p11 = bank_q[{py1, px1}];

  for (genvar ch = 0; ch < bis_pkg::NUM_CH; ch++) begin : g_lane
    bis_lane u_lane (
      .clk (clk),
      .a   (p00[ch*bis_pkg::CH_W +: bis_pkg::CH_W]),
      .b   (p10[ch*bis_pkg::CH_W +: bis_pkg::CH_W]),
      .c   (p01[ch*bis_pkg::CH_W +: bis_pkg::CH_W]),
      .d   (p11[ch*bis_pkg::CH_W +: bis_pkg::CH_W]),
      .fx  (rd_fx),
      .fy  (rd_fy),
      .q   (lane_q[ch])
    );
    assign blend[ch*bis_pkg::CH_W +: bis_pkg::CH_W] = lane_q[ch];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_l <= '0;
    end else begin
      vld_l <= {vld_l[1:0], rd_vld};
    end
  end

  always_ff @(posedge clk) begin
    samp_l <= {samp_l[1:0], rd_samp};
  end

  // merge lanes or substitute background
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_l[2];
    end
  end

  always_ff @(posedge clk) begin
    result.pixel_out <= samp_l[2] ? blend : background_color;
    result.sampled   <= samp_l[2];
  end

endmodule

### rtl/bis_checker.sv
// bis_checker: port-level assertions for the scaler top level, bound to it below
// depends on bis_pkg and bilinear_image_scaler_unit
module bis_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input bis_pkg::item_t            item,
  input logic                      done,
  input logic                      cfg_ready
);

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy not raised after reset");

  a_busy_clears: assert property (@(posedge clk) !rst |=> !busy)
    else $error("busy held outside reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && item.operation == bis_pkg::OP_REQUEST,
                   bis_pkg::LATENCY))
    else $error("result without a request transaction");

  a_cfg_always_ready: assert property (@(posedge clk) cfg_ready)
    else $error("config channel not ready");

endmodule

bind bilinear_image_scaler_unit bis_checker u_bis_checker (.*);
